### hw/rtl/sn3_pkg.sv
// shared types, constants and helper functions for the 3d simplex noise block
// no dependencies; imported by simplex_noise_3d and its testbench
package sn3_pkg;

  // fraction bits of the falloff term t and its powers
  localparam int TQ = 24;

  // permutation shuffle generator constants
  localparam logic [31:0] GEN_INC = 32'h6d2b79f5;
  localparam logic [31:0] GEN_MUL = 32'd61;

  // reciprocals for division by constants
  localparam logic [31:0] R3   = 32'((64'd1 << 33) / 3);
  localparam logic [31:0] R180 = 32'((64'd1 << 39) / 180);

  // sequencer states
  typedef enum logic [27:0] {
    ST_IDLE   = 28'd1 << 0,
    ST_FILL   = 28'd1 << 1,
    ST_GEN1   = 28'd1 << 2,
    ST_GEN2   = 28'd1 << 3,
    ST_GEN3   = 28'd1 << 4,
    ST_GEN4   = 28'd1 << 5,
    ST_RDI    = 28'd1 << 6,
    ST_RDJ    = 28'd1 << 7,
    ST_WRI    = 28'd1 << 8,
    ST_WRJ    = 28'd1 << 9,
    ST_QPRE   = 28'd1 << 10,
    ST_QDIV   = 28'd1 << 11,
    ST_QOFF   = 28'd1 << 12,
    ST_QORD   = 28'd1 << 13,
    ST_QHASH  = 28'd1 << 14,
    ST_QHWAIT = 28'd1 << 15,
    ST_KXYZ   = 28'd1 << 16,
    ST_KSQX   = 28'd1 << 17,
    ST_KSQY   = 28'd1 << 18,
    ST_KSQZ   = 28'd1 << 19,
    ST_KT5    = 28'd1 << 20,
    ST_KRCP   = 28'd1 << 21,
    ST_KCOR   = 28'd1 << 22,
    ST_KT2    = 28'd1 << 23,
    ST_KT4    = 28'd1 << 24,
    ST_KTRM   = 28'd1 << 25,
    ST_QRND   = 28'd1 << 26,
    ST_QFIN   = 28'd1 << 27
  } state_t;

  // floor(m / 3) by reciprocal multiply and one correction step
  function automatic logic [31:0] div3(input logic [31:0] m);
    logic [63:0] p;
    logic [31:0] est;
    logic [31:0] rem;
    p   = 64'(m) * 64'(R3);
    est = 32'(p[63:33]);
    rem = m - est * 32'd3;
    if (rem >= 32'd3) begin
      est = est + 32'd1;
    end
    return est;
  endfunction

  // v mod 12 for an 8-bit value by conditional subtraction
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [7:0] a;
    a = v;
    if (a >= 8'd192) a = a - 8'd192;
    if (a >= 8'd96)  a = a - 8'd96;
    if (a >= 8'd48)  a = a - 8'd48;
    if (a >= 8'd24)  a = a - 8'd24;
    if (a >= 8'd12)  a = a - 8'd12;
    return a[3:0];
  endfunction

endpackage

### hw/rtl/sn3_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module sn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/simplex_noise_3d.sv
// top level of the 3d simplex noise block: sequencer, datapath and permutation table
// depends on sn3_pkg and sn3_ram
//
// Takes a point (x, y, z) in signed fixed point with COORD_FRAC_BITS fraction bits and
// returns one sample of 3d simplex noise in signed fixed point with OUT_FRAC_BITS fraction
// bits, saturated to 16 bits. After reset and after every seed write the permutation
// table is rebuilt from the seed: a fill pass, then 255 shuffle steps, each reading both
// entries before writing either, with in_tready low the whole time. Items are handled one
// at a time; each passes the cell, offset, order and hash states, then the corner states,
// bound by the single read port of the permutation ram (twelve dependent lookups, one per cycle)
// and by one shared multiplier path that works each of the four corners in ten steps. The next
// input is taken while a finished result still waits for out_tready. COORD_FRAC_BITS may
// range from 8 to 24 and OUT_FRAC_BITS from 10 to 15.
module simplex_noise_3d
  import sn3_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,   // seed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,    // coord_x, coord_y, coord_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // noise_value
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int OW  = F + 5;
  localparam int DW  = OW + 1;
  localparam int RW  = 2 * OW;
  localparam int T5W = RW + 8;
  localparam int QW  = 36 - F;
  localparam int TW  = OW + 28;
  localparam int RE  = TQ + F - 4 - OUT_FRAC_BITS;
  localparam int SHR = (2 * F >= TQ) ? 2 * F - TQ : 0;
  localparam int SHL = (2 * F >= TQ) ? 0 : TQ - 2 * F;

  localparam logic [OW-1:0]        SIX_ONE = OW'(6) << F;
  localparam logic [QW:0]          OFFQ    = (QW + 1)'(3) << (QW - 1);
  localparam logic signed [TW-1:0] HALF_D  = TW'(3) << (RE - 1);
  localparam logic signed [TW-1:0] W_MIN   = TW'(-98304);
  localparam logic signed [TW-1:0] W_MAX   = TW'(98303);

  state_t state_r, state_nxt;
  logic   ready_r;

  // table build registers
  logic [7:0]  idx_r, j_r, pi_r;
  logic [31:0] gs_r, gt_r, gp_r, gu_r;

  // query registers
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [33:0] s_r;
  logic [1:0]         ax_r;
  logic [QW:0]        m_r;
  logic [7:0]         cell_r [3];
  logic signed [OW-1:0] x0_r, y0_r, z0_r;
  logic [2:0]         off1_r, off2_r;
  logic [1:0]         hc_r, lvl_r, capc_r, cn_r;
  logic               cap_r;
  logic [3:0]         g_r [4];
  logic signed [OW-1:0] xc_r, yc_r, zc_r;
  logic signed [DW-1:0] dot_r;
  logic [RW-1:0]      r_r;
  logic               pos_r;
  logic [30:0]        v_r;
  logic [23:0]        est_r, tq_r, t2_r, t4_r;
  logic signed [TW-1:0] total_r;
  logic [17:0]        mw_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  // ram ports
  logic       ram_we;
  logic [7:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  sn3_ram #(.WIDTH(8), .DEPTH(256)) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE) && ready_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // corner offset bits {k, j, i} for the hash and for the corner datapath
  logic [2:0] cb_h, cb_k;
  always_comb begin
    case (hc_r)
      2'd0:    cb_h = 3'b000;
      2'd1:    cb_h = off1_r;
      2'd2:    cb_h = off2_r;
      default: cb_h = 3'b111;
    endcase
    case (cn_r)
      2'd0:    cb_k = 3'b000;
      2'd1:    cb_k = off1_r;
      2'd2:    cb_k = off2_r;
      default: cb_k = 3'b111;
    endcase
  end

  // hash chain address: z level, then y, then x, the y and x levels adding the last lookup
  logic [7:0] hash_addr;
  always_comb begin
    case (lvl_r)
      2'd0:    hash_addr = cell_r[2] + 8'(cb_h[2]);
      2'd1:    hash_addr = cell_r[1] + 8'(cb_h[1]) + ram_rdata;
      default: hash_addr = cell_r[0] + 8'(cb_h[0]) + ram_rdata;
    endcase
  end

  // ram access per state; the shuffle reads both entries before writing either
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = idx_r;
    ram_raddr = idx_r;
    case (state_r)
      ST_FILL: ram_we = 1'b1;
      ST_RDJ:  ram_raddr = j_r;
      ST_WRI: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = pi_r;
      end
      ST_QHASH: ram_raddr = hash_addr;
      default: ram_raddr = idx_r;
    endcase
  end

  // generator and shuffle index arithmetic
  logic [31:0] gen_s, gen_t3;
  logic [40:0] jprod;
  always_comb begin
    gen_s  = gs_r + GEN_INC;
    gen_t3 = (gt_r + gp_r) ^ gt_r;
    jprod  = 41'(gu_r) * 41'(9'(idx_r) + 9'd1);
  end

  // cell index: floor((3c + s) / (3 * one))
  logic signed [31:0] c_sel;
  logic signed [35:0] n_cell;
  logic signed [QW-1:0] q_cell;
  logic [31:0] d3_cell;
  always_comb begin
    case (ax_r)
      2'd0:    c_sel = x_r;
      2'd1:    c_sel = y_r;
      default: c_sel = z_r;
    endcase
    n_cell  = 36'(c_sel) * 36'sd3 + 36'(s_r);
    q_cell  = QW'(n_cell >>> F);
    d3_cell = div3(32'(m_r));
  end

  // unskewed offsets of the first corner, exact modulo 2^OW
  logic [7:0]    csum;
  logic [OW-1:0] x0_w, y0_w, z0_w;
  always_comb begin
    csum = cell_r[0] + cell_r[1] + cell_r[2];
    x0_w = OW'(x_r) * OW'(6) - ((OW'(cell_r[0]) * OW'(6)) << F) + (OW'(csum) << F);
    y0_w = OW'(y_r) * OW'(6) - ((OW'(cell_r[1]) * OW'(6)) << F) + (OW'(csum) << F);
    z0_w = OW'(z_r) * OW'(6) - ((OW'(cell_r[2]) * OW'(6)) << F) + (OW'(csum) << F);
  end

  // simplex corner order from the offset ranking
  logic [2:0] o1_w, o2_w;
  always_comb begin
    if (x0_r >= y0_r) begin
      if (y0_r >= z0_r) begin
        o1_w = 3'b001; o2_w = 3'b011;
      end else if (x0_r >= z0_r) begin
        o1_w = 3'b001; o2_w = 3'b101;
      end else begin
        o1_w = 3'b100; o2_w = 3'b101;
      end
    end else if (y0_r < z0_r) begin
      o1_w = 3'b100; o2_w = 3'b110;
    end else if (x0_r < z0_r) begin
      o1_w = 3'b010; o2_w = 3'b110;
    end else begin
      o1_w = 3'b010; o2_w = 3'b011;
    end
  end

  // corner position and gradient dot product
  logic [OW-1:0] cconst;
  logic signed [DW-1:0] xe, ye, ze, dot_w;
  always_comb begin
    cconst = OW'(cn_r) << F;
    xe = DW'(xc_r);
    ye = DW'(yc_r);
    ze = DW'(zc_r);
    case (g_r[cn_r])
      4'd0:    dot_w =  xe + ye;
      4'd1:    dot_w = -xe + ye;
      4'd2:    dot_w =  xe - ye;
      4'd3:    dot_w = -xe - ye;
      4'd4:    dot_w =  xe + ze;
      4'd5:    dot_w = -xe + ze;
      4'd6:    dot_w =  xe - ze;
      4'd7:    dot_w = -xe - ze;
      4'd8:    dot_w =  ye + ze;
      4'd9:    dot_w = -ye + ze;
      4'd10:   dot_w =  ye - ze;
      4'd11:   dot_w = -ye - ze;
      default: dot_w = '0;
    endcase
  end

  // shared square, falloff and product path
  logic signed [OW-1:0] sq_op;
  logic signed [RW-1:0] sq;
  logic signed [T5W-1:0] t5;
  logic [30:0] v_w;
  logic [62:0] rcp;
  logic [31:0] rem180;
  logic [47:0] pw2, pw4;
  logic signed [TW-1:0] term, w_rnd, w_cl;
  logic [31:0] d3_out;
  always_comb begin
    case (state_r)
      ST_KSQX: sq_op = xc_r;
      ST_KSQY: sq_op = yc_r;
      default: sq_op = zc_r;
    endcase
    sq     = RW'(sq_op) * RW'(sq_op);
    t5     = $signed(T5W'(108) << (2 * F)) - $signed(T5W'(r_r) * T5W'(5));
    v_w    = (2 * F >= TQ) ? 31'(t5 >>> SHR) : 31'(t5 <<< SHL);
    rcp    = 63'(v_r) * 63'(R180);
    rem180 = 32'(v_r) - 32'(est_r) * 32'd180;
    pw2    = 48'(tq_r) * 48'(tq_r);
    pw4    = 48'(t2_r) * 48'(t2_r);
    term   = TW'($signed({1'b0, t4_r})) * TW'(dot_r);
    w_rnd  = (total_r + HALF_D) >>> RE;
    if (w_rnd < W_MIN) begin
      w_cl = W_MIN;
    end else if (w_rnd > W_MAX) begin
      w_cl = W_MAX;
    end else begin
      w_cl = w_rnd;
    end
    d3_out = div3(32'(mw_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_QPRE;
      ST_FILL:   if (idx_r == 8'd255) state_nxt = ST_GEN1;
      ST_GEN1:   state_nxt = ST_GEN2;
      ST_GEN2:   state_nxt = ST_GEN3;
      ST_GEN3:   state_nxt = ST_GEN4;
      ST_GEN4:   state_nxt = ST_RDI;
      ST_RDI:    state_nxt = ST_RDJ;
      ST_RDJ:    state_nxt = ST_WRI;
      ST_WRI:    state_nxt = ST_WRJ;
      ST_WRJ:    state_nxt = (idx_r == 8'd1) ? ST_IDLE : ST_GEN1;
      ST_QPRE:   state_nxt = ST_QDIV;
      ST_QDIV:   state_nxt = (ax_r == 2'd2) ? ST_QOFF : ST_QPRE;
      ST_QOFF:   state_nxt = ST_QORD;
      ST_QORD:   state_nxt = ST_QHASH;
      ST_QHASH:  if (hc_r == 2'd3 && lvl_r == 2'd2) state_nxt = ST_QHWAIT;
      ST_QHWAIT: state_nxt = ST_KXYZ;
      ST_KXYZ:   state_nxt = ST_KSQX;
      ST_KSQX:   state_nxt = ST_KSQY;
      ST_KSQY:   state_nxt = ST_KSQZ;
      ST_KSQZ:   state_nxt = ST_KT5;
      ST_KT5:    state_nxt = ST_KRCP;
      ST_KRCP:   state_nxt = ST_KCOR;
      ST_KCOR:   state_nxt = ST_KT2;
      ST_KT2:    state_nxt = ST_KT4;
      ST_KT4:    state_nxt = ST_KTRM;
      ST_KTRM:   state_nxt = (cn_r == 2'd3) ? ST_QRND : ST_KXYZ;
      ST_QRND:   state_nxt = ST_QFIN;
      ST_QFIN:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      state_nxt = ST_FILL;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ready_r     <= 1'b0;
      gs_r        <= '0;
      idx_r       <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= (state_r == ST_QHASH) && (lvl_r == 2'd2);
      // result held until its transfer, refilled when the last query finishes
      out_valid_r <= (out_valid_r && !out_tready)
                   || (state_r == ST_QFIN && (!out_valid_r || out_tready));
      if (cfg_we) begin
        gs_r    <= cfg_wdata;
        idx_r   <= '0;
        ready_r <= 1'b0;
      end else begin
        case (state_r)
          ST_FILL: if (idx_r != 8'd255) idx_r <= idx_r + 8'd1;
          ST_GEN1: gs_r <= gen_s;
          ST_WRJ: begin
            idx_r <= idx_r - 8'd1;
            if (idx_r == 8'd1) ready_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cap_r) begin
      g_r[capc_r] <= mod12(ram_rdata);
    end
    case (state_r)
      ST_IDLE: begin
        x_r  <= $signed(in_tdata[31:0]);
        y_r  <= $signed(in_tdata[63:32]);
        z_r  <= $signed(in_tdata[95:64]);
        s_r  <= 34'($signed(in_tdata[31:0])) + 34'($signed(in_tdata[63:32]))
              + 34'($signed(in_tdata[95:64]));
        ax_r <= 2'd0;
      end
      ST_GEN1: gt_r <= (gen_s ^ (gen_s >> 15)) * (gen_s | 32'd1);
      ST_GEN2: gp_r <= (gt_r ^ (gt_r >> 7)) * (gt_r | GEN_MUL);
      ST_GEN3: gu_r <= gen_t3 ^ (gen_t3 >> 14);
      ST_GEN4: j_r  <= jprod[39:32];
      ST_RDJ:  pi_r <= ram_rdata;
      ST_QPRE: m_r  <= (QW + 1)'(q_cell) + OFFQ;
      ST_QDIV: begin
        cell_r[ax_r] <= d3_cell[7:0];
        ax_r         <= ax_r + 2'd1;
      end
      ST_QOFF: begin
        x0_r <= $signed(x0_w);
        y0_r <= $signed(y0_w);
        z0_r <= $signed(z0_w);
      end
      ST_QORD: begin
        off1_r  <= o1_w;
        off2_r  <= o2_w;
        hc_r    <= 2'd0;
        lvl_r   <= 2'd0;
        cn_r    <= 2'd0;
        total_r <= '0;
      end
      ST_QHASH: begin
        capc_r <= hc_r;
        if (lvl_r == 2'd2) begin
          lvl_r <= 2'd0;
          hc_r  <= hc_r + 2'd1;
        end else begin
          lvl_r <= lvl_r + 2'd1;
        end
      end
      ST_KXYZ: begin
        xc_r <= $signed(OW'(x0_r) - (cb_k[0] ? SIX_ONE : '0) + cconst);
        yc_r <= $signed(OW'(y0_r) - (cb_k[1] ? SIX_ONE : '0) + cconst);
        zc_r <= $signed(OW'(z0_r) - (cb_k[2] ? SIX_ONE : '0) + cconst);
      end
      ST_KSQX: begin
        r_r   <= RW'(sq);
        dot_r <= dot_w;
      end
      ST_KSQY, ST_KSQZ: r_r <= r_r + RW'(sq);
      ST_KT5: begin
        pos_r <= (t5 > 0);
        v_r   <= v_w;
      end
      ST_KRCP: est_r <= rcp[62:39];
      ST_KCOR: tq_r  <= est_r + 24'(rem180 >= 32'd180);
      ST_KT2:  t2_r  <= pw2[47:24];
      ST_KT4:  t4_r  <= pw4[47:24];
      ST_KTRM: begin
        if (pos_r) total_r <= total_r + term;
        cn_r <= cn_r + 2'd1;
      end
      ST_QRND: mw_r <= 18'(w_cl + TW'(98304));
      ST_QFIN: begin
        if (!out_valid_r || out_tready) out_data_r <= d3_out[15:0] ^ 16'h8000;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // inputs are only taken with a finished table
  a_ready_table: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> ready_r)
    else $error("input taken before the permutation table was built");

  // a seed write restarts the table build
  a_seed_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == ST_FILL) && !ready_r && !in_tready)
    else $error("seed write did not restart the table build");

  // the table is never written while queries are served
  a_no_query_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ready_r)
    else $error("permutation table written while marked ready");

  // an input transfer starts the cell computation
  a_start_query: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !cfg_we |=> state_r == ST_QPRE)
    else $error("input transfer did not start a query");
`endif

endmodule

### tb/sv/simplex_noise_3d_tb.sv
// self-checking testbench for simplex_noise_3d: directed table, then random points
// across several seeds; depends on sn3_pkg and the simplex_noise_3d rtl
module simplex_noise_3d_tb
  import sn3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int OB = 14;
  localparam longint ONE = longint'(1) << FB;
  localparam int N_RANDOM = 700;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  simplex_noise_3d #(.COORD_FRAC_BITS(FB), .OUT_FRAC_BITS(OB)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state: seed, shuffled table and its valid flag
  logic [31:0] model_seed;
  logic [7:0]  perm_model [256];
  bit          perm_built;
  logic [15:0] noise_expected [$];
  int          n_errors;
  int          n_checked;
  int          n_sent;
  bit          fast_sink;

  // directed stimulus rows
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    logic [15:0] noise;
  } point_row_t;

  point_row_t directed_points [20] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 16'h0000},
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 16'h0000},
    '{32'hfffd_0000, 32'hfffd_0000, 32'hfffd_0000, 1, 16'h0000},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 16'h0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 16'h0},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 0, 16'h0},
    '{32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 0, 16'h0},
    '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, 16'h0},
    '{32'h0000_1999, 32'h0000_3333, 32'h0000_4ccc, 0, 16'h0},
    '{32'h0000_1999, 32'h0000_4ccc, 32'h0000_3333, 0, 16'h0},
    '{32'h0000_3333, 32'h0000_1999, 32'h0000_4ccc, 0, 16'h0},
    '{32'h0000_3333, 32'h0000_4ccc, 32'h0000_1999, 0, 16'h0},
    '{32'h0000_4ccc, 32'h0000_1999, 32'h0000_3333, 0, 16'h0},
    '{32'h0000_4ccc, 32'h0000_3333, 32'h0000_1999, 0, 16'h0},
    // ties between offsets
    '{32'h0000_8000, 32'h0000_8000, 32'h0000_0000, 0, 16'h0},
    '{32'h0000_8000, 32'h0000_0000, 32'h0000_8000, 0, 16'h0},
    '{32'h0000_0000, 32'h0000_8000, 32'h0000_8000, 0, 16'h0},
    // cell index wrap at 256
    '{32'h00ff_8000, 32'h0100_4000, 32'hff00_2000, 0, 16'h0},
    '{32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 0, 16'h0},
    '{32'h0002_a3d7, 32'hfffe_1234, 32'h0000_c000, 0, 16'h0}
  };

  // gradients toward the edge midpoints of a cube
  int grad_x [12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  int grad_y [12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
  int grad_z [12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

  // fisher-yates shuffle of the permutation table from the seed
  function automatic void shuffle_perm();
    logic [31:0] s, t, u, j;
    logic [7:0]  tmp;
    s = model_seed;
    for (int i = 0; i < 256; i++) perm_model[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      s = s + GEN_INC;
      t = (s ^ (s >> 15)) * (32'd1 | s);
      t = (t + ((t ^ (t >> 7)) * (GEN_MUL | t))) ^ t;
      u = t ^ (t >> 14);
      j = 32'((64'(u) * 64'(i + 1)) >> 32);
      tmp = perm_model[i];
      perm_model[i] = perm_model[j[7:0]];
      perm_model[j[7:0]] = tmp;
    end
    perm_built = 1;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic int gradient_index(longint a, longint b, longint c);
    int h;
    h = perm_model[c & 255];
    h = perm_model[(b + h) & 255];
    h = perm_model[(a + h) & 255];
    return h % 12;
  endfunction

  // contribution of one corner: falloff^4 times gradient dot offset
  function automatic longint corner_term(longint dx, longint dy, longint dz, int g);
    longint r, t5, tq, t2, t4;
    r  = dx * dx + dy * dy + dz * dz;
    t5 = 108 * ONE * ONE - 5 * r;
    if (t5 <= 0) return 0;
    tq = t5 / (longint'(180) << (2 * FB - TQ));
    t2 = (tq * tq) >>> TQ;
    t4 = (t2 * t2) >>> TQ;
    return t4 * (grad_x[g] * dx + grad_y[g] * dy + grad_z[g] * dz);
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    longint x, y, z, s, ci, cj, ck, c, x0, y0, z0, total, dv, v;
    int i1, j1, k1, i2, j2, k2;
    if (!perm_built) shuffle_perm();
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    s = x + y + z;
    ci = floor_quot(3 * x + s, 3 * ONE);
    cj = floor_quot(3 * y + s, 3 * ONE);
    ck = floor_quot(3 * z + s, 3 * ONE);
    c = ci + cj + ck;
    x0 = 6 * x - 6 * ONE * ci + ONE * c;
    y0 = 6 * y - 6 * ONE * cj + ONE * c;
    z0 = 6 * z - 6 * ONE * ck + ONE * c;
    {i1, j1, k1, i2, j2, k2} = '0;
    // pick the simplex corners from the offset order
    if (x0 >= y0) begin
      if (y0 >= z0) begin
        i1 = 1; i2 = 1; j2 = 1;
      end else if (x0 >= z0) begin
        i1 = 1; i2 = 1; k2 = 1;
      end else begin
        k1 = 1; i2 = 1; k2 = 1;
      end
    end else if (y0 < z0) begin
      k1 = 1; j2 = 1; k2 = 1;
    end else if (x0 < z0) begin
      j1 = 1; j2 = 1; k2 = 1;
    end else begin
      j1 = 1; i2 = 1; j2 = 1;
    end
    ci = ci & 255;
    cj = cj & 255;
    ck = ck & 255;
    total = corner_term(x0, y0, z0, gradient_index(ci, cj, ck));
    total += corner_term(x0 - 6 * ONE * i1 + ONE, y0 - 6 * ONE * j1 + ONE,
                         z0 - 6 * ONE * k1 + ONE,
                         gradient_index(ci + i1, cj + j1, ck + k1));
    total += corner_term(x0 - 6 * ONE * i2 + 2 * ONE, y0 - 6 * ONE * j2 + 2 * ONE,
                         z0 - 6 * ONE * k2 + 2 * ONE,
                         gradient_index(ci + i2, cj + j2, ck + k2));
    total += corner_term(x0 - 3 * ONE, y0 - 3 * ONE, z0 - 3 * ONE,
                         gradient_index(ci + 1, cj + 1, ck + 1));
    dv = longint'(6) << (TQ + FB - 5 - OB);
    v = floor_quot(total + dv / 2, dv);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] random_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
      2: return ($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_0000)
                + 32'($urandom_range(0, 32'hffff));
      default: return 32'($signed($urandom_range(0, 60)) - 30) * 32'd21845;
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, compare at the rising edge
  initial begin
    int stall;
    out_tready = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 0;
        stall--;
      end else begin
        out_tready <= 1;
        if (!fast_sink) stall = idle_cycles();
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (noise_expected.size() == 0) begin
          $error("noise_value: unexpected transfer, actual %0d", $signed(out_tdata));
          n_errors++;
        end else begin
          logic [15:0] want;
          want = noise_expected.pop_front();
          if (out_tdata !== want) begin
            $error("noise_value: expected %0d, actual %0d", $signed(want),
                   $signed(out_tdata));
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  // one input transfer; valid stays high across back-to-back points
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit known, logic [15:0] noise);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {pz, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (known) begin
      void'(noise_at(px, py, pz));
      noise_expected.push_back(noise);
    end else begin
      noise_expected.push_back(noise_at(px, py, pz));
    end
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 0;
    while (noise_expected.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    cfg_we    <= 1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we     <= 0;
    model_seed = value;
    perm_built = 0;
  endtask

  // reset, directed rows, then random phases over several seeds
  initial begin
    logic [31:0] seeds [4];
    int kind;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_tvalid = 0;
    in_tdata = '0;
    fast_sink = 0;
    model_seed = '0;
    perm_built = 0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    seeds = '{32'hffff_ffff, 32'h0000_0001, $urandom, 32'h8000_0000};
    repeat (9) @(negedge clk);
    rst_n = 1;

    foreach (directed_points[r])
      send_point(directed_points[r].x, directed_points[r].y, directed_points[r].z,
                 directed_points[r].known, directed_points[r].noise);

    for (int p = 0; p < 4; p++) begin
      drain_and_idle();
      write_seed(seeds[p]);
      fast_sink = (p == 2);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        kind = $urandom_range(0, 3);
        send_point(random_coord(kind), random_coord(kind), random_coord(kind), 0, '0);
        // hold off until every pending result has arrived
        if (n == 40) begin
          in_tvalid <= 0;
          while (noise_expected.size() != 0) @(negedge clk);
        end
      end
    end

    in_tvalid <= 0;
    while (noise_expected.size() != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d points, %0d results checked, over five seeds incl. 0 and all-ones",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sn3_pkg.sv
hw/rtl/sn3_ram.sv
hw/rtl/simplex_noise_3d.sv
tb/sv/simplex_noise_3d_tb.sv
